### hdl/tti_pkg.sv
// tti_pkg: shared types, constants and helpers for the trajectory table interpolator
// no dependencies; imported by trajectory_table_interpolator_core
package tti_pkg;

   localparam int FRAC_BITS = 16;
   localparam logic signed [21:0] ONE_Q = 22'sd1 <<< FRAC_BITS;
   localparam longint PI_L     = (64'd3373259426 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
   localparam longint TWO_PI_L = (64'd6746518852 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
   localparam logic signed [21:0] PI_Q     = 22'(PI_L);
   localparam logic signed [21:0] TWO_PI_Q = 22'(TWO_PI_L);

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;

   localparam int ENTRY_W = 32 + 31 + 22 + 19 + 25;

   typedef struct packed {
      logic signed [31:0] time_v;
      logic        [30:0] arc;
      logic signed [21:0] spd;
      logic signed [18:0] hdg;
      logic signed [24:0] kap;
   } entry_type;

   typedef enum logic [16:0] {
      S_IDLE     = 17'b00000000000000001,
      S_LAST_RD  = 17'b00000000000000010,
      S_LAST_CHK = 17'b00000000000000100,
      S_SEG      = 17'b00000000000001000,
      S_RD0      = 17'b00000000000010000,
      S_GET0     = 17'b00000000000100000,
      S_RD1      = 17'b00000000001000000,
      S_GET1     = 17'b00000000010000000,
      S_DIV      = 17'b00000000100000000,
      S_M_ARC    = 17'b00000001000000000,
      S_M_SPD    = 17'b00000010000000000,
      S_M_KAP    = 17'b00000100000000000,
      S_M_HDG    = 17'b00001000000000000,
      S_M_TURN   = 17'b00010000000000000,
      S_FIN      = 17'b00100000000000000,
      S_RD_END   = 17'b01000000000000000,
      S_GET_END  = 17'b10000000000000000
   } state_type;

   // wrap into [-pi, pi); correct for input within [-3pi, 3pi)
   function automatic logic signed [21:0] wrap_angle(input logic signed [21:0] x);
      logic signed [21:0] r;
      r = x + PI_Q;
      if (r < 0) begin
         r = r + TWO_PI_Q;
      end else if (r >= TWO_PI_Q) begin
         r = r - TWO_PI_Q;
      end
      return r - PI_Q;
   endfunction

endpackage

### hdl/trajectory_table_interpolator_core.sv
// trajectory_table_interpolator_core: point table with time-indexed linear interpolation
// clear and append take effect while idle; a query holds the block (req_stall high) until its result is issued,
// on an empty table, at an end point or when it interpolates through the serial ratio divider, one beat at a time
// the shared multiplier and the single ram read port make the query steps run one after another
// synchronous active-high reset empties the table and sets freq_ff to 20; ram is not cleared
// depends on tti_pkg and tti_ram
module trajectory_table_interpolator_core
   import tti_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [13:0]        csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_command,
   input  logic signed [31:0] req_time_value,
   input  logic [30:0]        req_arc_in,
   input  logic signed [21:0] req_speed_in,
   input  logic signed [18:0] req_heading_in,
   input  logic signed [24:0] req_curvature_in,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_valid_res,
   output logic signed [31:0] rsp_out_time,
   output logic [30:0]        rsp_out_arc,
   output logic signed [21:0] rsp_out_speed,
   output logic signed [18:0] rsp_out_heading,
   output logic signed [24:0] rsp_out_curvature,
   output logic signed [23:0] rsp_out_turn_rate
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   // control
   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [13:0]   freq_ff, freq_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [4:0]    div_cnt_ff, div_cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // datapath
   logic signed [31:0] t_ff, t_in;
   logic signed [31:0] p0_time_ff, p0_time_in;
   logic signed [31:0] darc_ff, darc_in;
   logic signed [22:0] dspd_ff, dspd_in;
   logic signed [25:0] dkap_ff, dkap_in;
   logic signed [21:0] dh_ff, dh_in;
   logic [16:0]        ratio_ff, ratio_in;
   logic [33:0]        rem_ff, rem_in;
   logic [32:0]        dur_ff, dur_in;
   logic [15:0]        quo_ff, quo_in;
   logic               res_valid_ff, res_valid_in;
   logic signed [31:0] res_time_ff, res_time_in;
   logic [30:0]        res_arc_ff, res_arc_in;
   logic signed [21:0] res_spd_ff, res_spd_in;
   logic signed [18:0] res_hdg_ff, res_hdg_in;
   logic signed [24:0] res_kap_ff, res_kap_in;
   logic signed [55:0] prod_ff, prod_in;
   logic               o_valid_res_ff, o_valid_res_in;
   logic signed [31:0] o_time_ff, o_time_in;
   logic [30:0]        o_arc_ff, o_arc_in;
   logic signed [21:0] o_spd_ff, o_spd_in;
   logic signed [18:0] o_hdg_ff, o_hdg_in;
   logic signed [24:0] o_kap_ff, o_kap_in;
   logic signed [23:0] o_turn_ff, o_turn_in;

   // marks a query that went through the interpolation path
   logic interp_ff, interp_in;

   // shared multiplier operands
   logic signed [32:0] mul_a;
   logic signed [22:0] mul_b;
   logic               mul_en;

   // ram ports
   logic          wr_en;
   entry_type     wr_entry;
   entry_type     q;

   logic               accept;
   logic signed [39:0] scaled;
   logic signed [32:0] dur_s, num_s;
   logic [33:0]        rem2;
   logic [39:0]        seg;
   logic [CW-1:0]      cnt_m2;
   logic signed [39:0] turn_full;

   // heading accumulate happens as the turn product starts
   logic signed [21:0] hdg_sum;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign scaled    = 40'(prod_ff >>> FRAC_BITS);   // arithmetic shift is floor
   assign dur_s     = 33'(q.time_v) - 33'(p0_time_ff);
   assign num_s     = 33'(t_ff) - 33'(p0_time_ff);
   assign rem2      = {rem_ff[32:0], 1'b0};
   assign seg       = prod_ff[55:FRAC_BITS];
   assign cnt_m2    = count_ff - CW'(2);
   assign turn_full = scaled;
   assign hdg_sum   = wrap_angle(22'(res_hdg_ff) + 22'(scaled));

   assign wr_entry = '{time_v: req_time_value, arc: req_arc_in, spd: req_speed_in,
                       hdg: req_heading_in, kap: req_curvature_in};

   tti_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_entry),
      .rd_addr (addr_ff),
      .rd_data (q)
   );

   // operand select for the one multiplier
   always_comb begin
      mul_en = 1'b1;
      mul_a  = '0;
      mul_b  = '0;
      case (state_ff)
         S_LAST_CHK: begin
            mul_a = 33'(t_ff);
            mul_b = 23'({9'd0, freq_ff});
         end
         S_M_ARC: begin
            mul_a = 33'(darc_ff);
            mul_b = 23'({6'd0, ratio_ff});
         end
         S_M_SPD: begin
            mul_a = 33'(dspd_ff);
            mul_b = 23'({6'd0, ratio_ff});
         end
         S_M_KAP: begin
            mul_a = 33'(dkap_ff);
            mul_b = 23'({6'd0, ratio_ff});
         end
         S_M_HDG: begin
            mul_a = 33'(dh_ff);
            mul_b = 23'({6'd0, ratio_ff});
         end
         S_M_TURN: begin
            mul_a = 33'(res_kap_ff);
            mul_b = 23'(res_spd_ff);
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   assign prod_in = mul_en ? (56'(mul_a) * 56'(mul_b)) : prod_ff;

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      freq_in        = csr_wr_en ? csr_wr_data : freq_ff;
      addr_in        = addr_ff;
      idx_in         = idx_ff;
      div_cnt_in     = div_cnt_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      t_in           = t_ff;
      p0_time_in     = p0_time_ff;
      darc_in        = darc_ff;
      dspd_in        = dspd_ff;
      dkap_in        = dkap_ff;
      dh_in          = dh_ff;
      ratio_in       = ratio_ff;
      rem_in         = rem_ff;
      dur_in         = dur_ff;
      quo_in         = quo_ff;
      res_valid_in   = res_valid_ff;
      res_time_in    = res_time_ff;
      res_arc_in     = res_arc_ff;
      res_spd_in     = res_spd_ff;
      res_hdg_in     = res_hdg_ff;
      res_kap_in     = res_kap_ff;
      o_valid_res_in = o_valid_res_ff;
      o_time_in      = o_time_ff;
      o_arc_in       = o_arc_ff;
      o_spd_in       = o_spd_ff;
      o_hdg_in       = o_hdg_ff;
      o_kap_in       = o_kap_ff;
      o_turn_in      = o_turn_ff;
      wr_en          = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               t_in = req_time_value;
               case (req_command)
                  CMD_CLEAR: begin
                     count_in = '0;
                  end
                  CMD_APPEND: begin
                     if (count_ff < CW'(TABLE_DEPTH)) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  CMD_QUERY: begin
                     if (count_ff == '0) begin
                        // empty table: all-zero point, valid_res low
                        res_valid_in = 1'b0;
                        res_time_in  = '0;
                        res_arc_in   = '0;
                        res_spd_in   = '0;
                        res_hdg_in   = '0;
                        res_kap_in   = '0;
                        state_in     = S_M_TURN;
                     end else if (req_time_value <= 0 || count_ff == CW'(1)) begin
                        addr_in  = '0;
                        state_in = S_RD_END;
                     end else begin
                        addr_in  = AW'(count_ff - CW'(1));
                        state_in = S_LAST_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_RD_END: begin
            state_in = S_GET_END;
         end
         S_GET_END: begin
            // stored entry goes out as is
            res_valid_in = 1'b1;
            res_time_in  = q.time_v;
            res_arc_in   = q.arc;
            res_spd_in   = q.spd;
            res_hdg_in   = q.hdg;
            res_kap_in   = q.kap;
            state_in     = S_M_TURN;
         end
         S_LAST_RD: begin
            state_in = S_LAST_CHK;
         end
         S_LAST_CHK: begin
            res_valid_in = 1'b1;
            if (t_ff >= q.time_v) begin
               // at or past the last point
               res_time_in = q.time_v;
               res_arc_in  = q.arc;
               res_spd_in  = q.spd;
               res_hdg_in  = q.hdg;
               res_kap_in  = q.kap;
               state_in    = S_M_TURN;
            end else begin
               // multiplier forms t * freq for the segment index
               res_time_in = t_ff;
               state_in    = S_SEG;
            end
         end
         S_SEG: begin
            if (seg > 40'(cnt_m2)) begin
               idx_in = AW'(cnt_m2);
            end else begin
               idx_in = seg[AW-1:0];
            end
            addr_in  = idx_in;
            state_in = S_RD0;
         end
         S_RD0: begin
            addr_in  = idx_ff + AW'(1);
            state_in = S_GET0;
         end
         S_GET0: begin
            p0_time_in = q.time_v;
            res_arc_in = q.arc;
            res_spd_in = q.spd;
            res_hdg_in = q.hdg;
            res_kap_in = q.kap;
            state_in   = S_RD1;
         end
         S_RD1: begin
            state_in = S_GET1;
         end
         S_GET1: begin
            darc_in = 32'({1'b0, q.arc}) - 32'({1'b0, res_arc_ff});
            dspd_in = 23'(q.spd) - 23'(res_spd_ff);
            dkap_in = 26'(q.kap) - 26'(res_kap_ff);
            dh_in   = wrap_angle(22'(q.hdg) - 22'(res_hdg_ff));
            if (dur_s > 0 && num_s > 0) begin
               if (num_s >= dur_s) begin
                  ratio_in = 17'(ONE_Q);
                  state_in = S_M_ARC;
               end else begin
                  rem_in     = 34'(num_s);
                  dur_in     = dur_s;
                  quo_in     = '0;
                  div_cnt_in = '0;
                  state_in   = S_DIV;
               end
            end else begin
               ratio_in = '0;
               state_in = S_M_ARC;
            end
         end
         S_DIV: begin
            // restoring divider, one quotient bit a cycle
            if (rem2 >= {1'b0, dur_ff}) begin
               rem_in = rem2 - {1'b0, dur_ff};
               quo_in = {quo_ff[14:0], 1'b1};
            end else begin
               rem_in = rem2;
               quo_in = {quo_ff[14:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff + 5'd1;
            if (div_cnt_ff == 5'(FRAC_BITS - 1)) begin
               ratio_in = {1'b0, quo_in};
               state_in = S_M_ARC;
            end
         end
         S_M_ARC: begin
            state_in = S_M_SPD;
         end
         S_M_SPD: begin
            res_arc_in = 31'(40'({1'b0, res_arc_ff}) + scaled);
            state_in   = S_M_KAP;
         end
         S_M_KAP: begin
            res_spd_in = 22'(40'(res_spd_ff) + scaled);
            state_in   = S_M_HDG;
         end
         S_M_HDG: begin
            res_kap_in = 25'(40'(res_kap_ff) + scaled);
            state_in   = S_M_TURN;
         end
         S_M_TURN: begin
            // interpolated heading lands when the heading product is ready
            if (interp_ff) begin
               res_hdg_in = 19'(hdg_sum);
            end
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               o_valid_res_in = res_valid_ff;
               o_time_in      = res_time_ff;
               o_arc_in       = res_arc_ff;
               o_spd_in       = res_spd_ff;
               o_hdg_in       = res_hdg_ff;
               o_kap_in       = res_kap_ff;
               if (turn_full > 40'sd8388607) begin
                  o_turn_in = 24'sh7FFFFF;
               end else if (turn_full < -40'sd8388608) begin
                  o_turn_in = 24'sh800000;
               end else begin
                  o_turn_in = 24'(turn_full);
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         freq_ff      <= 14'd20;
         rsp_valid_ff <= 1'b0;
         div_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         freq_ff      <= freq_in;
         rsp_valid_ff <= rsp_valid_in;
         div_cnt_ff   <= div_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff        <= addr_in;
      idx_ff         <= idx_in;
      t_ff           <= t_in;
      p0_time_ff     <= p0_time_in;
      darc_ff        <= darc_in;
      dspd_ff        <= dspd_in;
      dkap_ff        <= dkap_in;
      dh_ff          <= dh_in;
      ratio_ff       <= ratio_in;
      rem_ff         <= rem_in;
      dur_ff         <= dur_in;
      quo_ff         <= quo_in;
      prod_ff        <= prod_in;
      res_valid_ff   <= res_valid_in;
      res_time_ff    <= res_time_in;
      res_arc_ff     <= res_arc_in;
      res_spd_ff     <= res_spd_in;
      res_hdg_ff     <= res_hdg_in;
      res_kap_ff     <= res_kap_in;
      o_valid_res_ff <= o_valid_res_in;
      o_time_ff      <= o_time_in;
      o_arc_ff       <= o_arc_in;
      o_spd_ff       <= o_spd_in;
      o_hdg_ff       <= o_hdg_in;
      o_kap_ff       <= o_kap_in;
      o_turn_ff      <= o_turn_in;
   end

   assign interp_in = (state_ff == S_M_HDG) ? 1'b1 :
                      (state_ff == S_IDLE)  ? 1'b0 : interp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         interp_ff <= 1'b0;
      end else begin
         interp_ff <= interp_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_valid_res     = o_valid_res_ff;
   assign rsp_out_time      = o_time_ff;
   assign rsp_out_arc       = o_arc_ff;
   assign rsp_out_speed     = o_spd_ff;
   assign rsp_out_heading   = o_hdg_ff;
   assign rsp_out_curvature = o_kap_ff;
   assign rsp_out_turn_rate = o_turn_ff;

`ifndef SYNTH
   // table fill never passes its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   // a new result beat only comes out of the final step
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FIN))
      else $error("result beat raised outside final step");

   // an accepted query always starts the sequencer
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && req_command == CMD_QUERY) |=> (state_ff != S_IDLE))
      else $error("query accepted but sequencer stayed idle");

   // divider never runs past its last quotient bit
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (div_cnt_ff < 5'(FRAC_BITS)))
      else $error("divider step count overran");
`endif

endmodule

### hdl/tti_ram.sv
// tti_ram: generic simple dual-port ram, one write port and one registered read port
// no dependencies
module tti_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
